// File: rtl/spq_pkg.sv
// Shared types, codes and constants of the sorted priority queue.
// No dependencies; the RTL files use it through scoped names, the testbench files import it.
`default_nettype none

package spq_pkg;

  localparam int TAG_W        = 32;
  localparam int PRIO_W       = 32;
  localparam int CAPACITY_DEF = 64;

  // Largest priority is reserved as a sentinel.
  localparam logic [PRIO_W-1:0] PRIO_RESERVED = {1'b0, {(PRIO_W-1){1'b1}}};

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_POP    = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One stored entry of a cell.
  typedef struct packed {
    logic              valid;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // Operation broadcast to every cell in the accept cycle.
  typedef struct packed {
    logic              ins;
    logic              pop;
    logic              qry;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } cell_cmd_t;

  // Clamp the reserved priority to the next lower value.
  function automatic logic [PRIO_W-1:0] take_priority(input logic [PRIO_W-1:0] raw);
    take_priority = (raw == PRIO_RESERVED) ? (PRIO_RESERVED - 1'b1) : raw;
  endfunction

endpackage

`default_nettype wire

// File: rtl/spq_in_if.sv
// Request channel of the sorted priority queue: valid/ready plus operation.
// Depends on spq_pkg for field widths.
`default_nettype none

interface spq_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        action;
  logic [spq_pkg::TAG_W-1:0]         item_tag;
  logic signed [spq_pkg::PRIO_W-1:0] item_priority;

  modport source (output valid, output action, output item_tag, output item_priority,
                  input ready);
  modport sink   (input valid, input action, input item_tag, input item_priority,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/spq_out_if.sv
// Response channel of the sorted priority queue: valid/ready plus result.
// Depends on spq_pkg for field widths; CNT_W sizes the entry count.
`default_nettype none

interface spq_out_if #(
  parameter int CNT_W = 7
);
  logic                              valid;
  logic                              ready;
  logic [spq_pkg::TAG_W-1:0]         out_tag;
  logic signed [spq_pkg::PRIO_W-1:0] out_priority;
  logic                              found;
  logic [1:0]                        status;
  logic                              now_empty;
  logic [CNT_W-1:0]                  entry_count;

  modport source (output valid, output out_tag, output out_priority, output found,
                  output status, output now_empty, output entry_count, input ready);
  modport sink   (input valid, input out_tag, input out_priority, input found,
                  input status, input now_empty, input entry_count, output ready);
endinterface

`default_nettype wire

// File: rtl/spq_cell.sv
// One cell of the sorted chain: holds a single entry, compares it against
// the broadcast operation and shifts with its neighbors. Depends on spq_pkg.
`default_nettype none

module spq_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire spq_pkg::cell_cmd_t cmd,
  input  wire spq_pkg::entry_t    left,
  input  wire logic               left_keep,
  input  wire spq_pkg::entry_t    right,
  output spq_pkg::entry_t         ent,
  output logic                    keep,
  output logic                    hit
);

  spq_pkg::entry_t ent_next;
  logic            match;

  // Keep position when own entry is valid and its priority is lower than or equal to the new one.
  assign keep  = ent.valid && ($signed(ent.prio) <= $signed(cmd.prio));
  assign match = ent.valid && (ent.prio == cmd.prio) && (ent.tag == cmd.tag);

  always_comb begin
    ent_next = ent;
    if (cmd.ins) begin
      if (!keep) begin
        if (left_keep) begin
          ent_next = spq_pkg::entry_t'{valid: 1'b1, prio: cmd.prio, tag: cmd.tag};
        end else begin
          ent_next = left;
        end
      end
    end else if (cmd.pop) begin
      ent_next = right;
    end
  end

  // Only the valid bit is reset; payload follows the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent.valid <= ent_next.valid;
    end
    ent.prio <= ent_next.prio;
    ent.tag  <= ent_next.tag;
    if (cmd.qry) begin
      hit <= match;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: a chain of spq_cell instances,
// occupancy counter, result stage and response register.
// Depends on spq_pkg, spq_in_if, spq_out_if and spq_cell.
//
//  channel | dir | payload                                          | handshake
//  --------+-----+--------------------------------------------------+----------
//  cmd     | in  | action, item_tag, item_priority                  | valid/ready
//  rsp     | out | out_tag, out_priority, found, status, now_empty, | valid/ready
//          |     | entry_count                                      |
//
// Cycles: one item per cycle sustained while rsp is not held; a result passes
//   through the result stage and then the response register onto rsp. Every cell compares and
//   shifts in the accept cycle, query hits are OR-reduced in the following
//   result stage.
// Reset: rst (synchronous) empties the chain by clearing every valid bit and
//   the occupancy counter, and clears pend_valid and rsp.valid; no clearing pass.
// Stalls: a held response backs up one pending result, then cmd.ready drops.
`default_nettype none

module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  wire logic clk,
  input  wire logic rst,
  spq_in_if.sink    cmd,
  spq_out_if.source rsp
);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  // Occupancy and chain.
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  spq_pkg::entry_t    cell_ent [CAPACITY];
  logic [CAPACITY-1:0] cell_keep;
  logic [CAPACITY-1:0] cell_hit;
  spq_pkg::cell_cmd_t cell_cmd;

  // Result stage between accept and response register.
  logic                      pend_valid;
  logic [1:0]                pend_action;
  logic [1:0]                pend_status;
  logic [spq_pkg::TAG_W-1:0] pend_tag;
  logic [spq_pkg::PRIO_W-1:0] pend_prio;
  logic [CNT_W-1:0]          pend_count;

  logic                      accept;
  logic                      pend_move;
  logic                      is_full;
  logic                      chain_empty;
  logic [spq_pkg::PRIO_W-1:0] prio_in;
  logic [1:0]                status_in;

  assign is_full     = (count == CNT_FULL);
  assign chain_empty = (count == '0);
  assign prio_in     = spq_pkg::take_priority(cmd.item_priority);

  // Advance the result stage whenever the response register is free or drains.
  assign pend_move = pend_valid && (!rsp.valid || rsp.ready);
  assign cmd.ready = !pend_valid || pend_move;
  assign accept    = cmd.valid && cmd.ready;

  // Broadcast the operation; a blocked insert or pop leaves every cell alone.
  always_comb begin
    cell_cmd.ins  = accept && (cmd.action == spq_pkg::ACT_INSERT) && !is_full;
    cell_cmd.pop  = accept && (cmd.action == spq_pkg::ACT_POP) && !chain_empty;
    cell_cmd.qry  = accept && (cmd.action == spq_pkg::ACT_QUERY);
    cell_cmd.prio = prio_in;
    cell_cmd.tag  = cmd.item_tag;
  end

  always_comb begin
    count_next = count;
    if (cell_cmd.ins) begin
      count_next = count + 1'b1;
    end else if (cell_cmd.pop) begin
      count_next = count - 1'b1;
    end
  end

  always_comb begin
    case (cmd.action)
      spq_pkg::ACT_INSERT: status_in = is_full     ? spq_pkg::ST_FULL  : spq_pkg::ST_OK;
      spq_pkg::ACT_POP:    status_in = chain_empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
      default:             status_in = spq_pkg::ST_OK;
    endcase
  end

  // Chain of cells: each one looks at its left and right neighbor only.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::entry_t left_ent;
    spq_pkg::entry_t right_ent;
    logic            left_keep;

    if (i == 0) begin : g_head
      assign left_ent  = '0;
      assign left_keep = 1'b1;
    end else begin : g_body
      assign left_ent  = cell_ent[i-1];
      assign left_keep = cell_keep[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = cell_ent[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cell_cmd),
      .left      (left_ent),
      .left_keep (left_keep),
      .right     (right_ent),
      .ent       (cell_ent[i]),
      .keep      (cell_keep[i]),
      .hit       (cell_hit[i])
    );
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      pend_valid <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        pend_valid <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end
      if (pend_move) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Capture the head entry on a pop before the chain shifts it out.
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_action <= cmd.action;
      pend_status <= status_in;
      pend_count  <= count_next;
      if (cell_cmd.pop) begin
        pend_tag  <= cell_ent[0].tag;
        pend_prio <= cell_ent[0].prio;
      end else begin
        pend_tag  <= '0;
        pend_prio <= '0;
      end
    end
  end

  // Response register; query hits were latched by the cells at accept.
  always_ff @(posedge clk) begin
    if (pend_move) begin
      rsp.out_tag      <= pend_tag;
      rsp.out_priority <= pend_prio;
      rsp.found        <= (pend_action == spq_pkg::ACT_QUERY) && (|cell_hit);
      rsp.status       <= pend_status;
      rsp.now_empty    <= (pend_count == '0);
      rsp.entry_count  <= pend_count;
    end
  end

endmodule

`default_nettype wire

// File: rtl/spq_checker.sv
// Port-level checks of the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue.
`default_nettype none

module spq_checker #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      rsp_valid,
  input wire logic                      rsp_ready,
  input wire logic [spq_pkg::TAG_W-1:0] out_tag,
  input wire logic                      found,
  input wire logic [1:0]                status,
  input wire logic                      now_empty,
  input wire logic [CNT_W-1:0]          entry_count
);

  // Hold a stalled response.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (now_empty == (entry_count == '0)))
    else $error("now_empty disagrees with entry_count");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == spq_pkg::ST_FULL) |-> (entry_count == CNT_W'(CAPACITY)))
    else $error("full status with free room");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == spq_pkg::ST_EMPTY) |-> (entry_count == '0) && (out_tag == '0)
      && !found)
    else $error("empty pop returned data or count");

endmodule

bind sorted_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .out_tag     (rsp.out_tag),
  .found       (rsp.found),
  .status      (rsp.status),
  .now_empty   (rsp.now_empty),
  .entry_count (rsp.entry_count)
);

`default_nettype wire

// File: tb/sv/spq_shadow_pkg.sv
`timescale 1ns / 100ps
// Shadow copy of the sorted priority queue for the testbench: mirrors the
// held entries, predicts each response and compares it. Depends on spq_pkg.

package spq_shadow_pkg;

  import spq_pkg::*;

  class spq_shadow;

    localparam logic signed [PRIO_W-1:0] PRIO_TOP  = PRIO_RESERVED;
    localparam int                       CNT_BITS  = $clog2(CAPACITY_DEF + 1);
    localparam int                       PRINT_CAP = 100;

    typedef struct {
      logic signed [PRIO_W-1:0] prio;
      logic [TAG_W-1:0]         tag;
    } held_entry_t;

    typedef struct {
      logic [TAG_W-1:0]         tag;
      logic signed [PRIO_W-1:0] prio;
      logic                     found;
      status_t                  status;
      logic                     empty;
      logic [CNT_BITS-1:0]      count;
    } response_t;

    held_entry_t held_entries[$];
    response_t   awaited_responses[$];
    int          mismatches;
    int          responses_seen;

    function new();
      mismatches     = 0;
      responses_seen = 0;
    endfunction

    function int pending();
      return awaited_responses.size();
    endfunction

    task report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_CAP) begin
        $display("[%0t] response %0d: %s", $time, responses_seen, what);
      end
    endtask

    // Apply one accepted request to the mirrored entries and queue its response.
    task apply_request(input action_t act, input logic [TAG_W-1:0] tag,
                       input logic signed [PRIO_W-1:0] raw_prio);
      response_t              r;
      held_entry_t            e;
      int                     pos;
      logic signed [PRIO_W-1:0] p;
      p        = (raw_prio == PRIO_TOP) ? PRIO_TOP - 1 : raw_prio;
      r.tag    = '0;
      r.prio   = '0;
      r.found  = 1'b0;
      r.status = ST_OK;
      case (act)
        ACT_INSERT: begin
          if (held_entries.size() >= CAPACITY_DEF) begin
            r.status = ST_FULL;
          end else begin
            pos = 0;
            while (pos < held_entries.size() && held_entries[pos].prio <= p) pos++;
            e.prio = p;
            e.tag  = tag;
            held_entries.insert(pos, e);
          end
        end
        ACT_POP: begin
          if (held_entries.size() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            e      = held_entries.pop_front();
            r.tag  = e.tag;
            r.prio = e.prio;
          end
        end
        ACT_QUERY: begin
          foreach (held_entries[i]) begin
            if (held_entries[i].prio == p && held_entries[i].tag == tag) r.found = 1'b1;
          end
        end
        default: ;
      endcase
      r.empty = (held_entries.size() == 0);
      r.count = CNT_BITS'(held_entries.size());
      awaited_responses.push_back(r);
    endtask

    task check_response(input logic [TAG_W-1:0] tag, input logic signed [PRIO_W-1:0] prio,
                        input logic found, input logic [1:0] status, input logic empty,
                        input logic [CNT_BITS-1:0] count);
      response_t r;
      responses_seen++;
      if (awaited_responses.size() == 0) begin
        report_mismatch("response arrived with none awaited");
        return;
      end
      r = awaited_responses.pop_front();
      if (tag !== r.tag)
        report_mismatch($sformatf("out_tag %h, expected %h", tag, r.tag));
      if (prio !== r.prio)
        report_mismatch($sformatf("out_priority %0d, expected %0d", prio, r.prio));
      if (found !== r.found)
        report_mismatch($sformatf("found %b, expected %b", found, r.found));
      if (status !== r.status)
        report_mismatch($sformatf("status %0d, expected %s", status, r.status.name()));
      if (empty !== r.empty)
        report_mismatch($sformatf("now_empty %b, expected %b", empty, r.empty));
      if (count !== r.count)
        report_mismatch($sformatf("entry_count %0d, expected %0d", count, r.count));
    endtask

  endclass

endpackage

// File: tb/sv/sorted_priority_queue_tb.sv
`timescale 1ns / 100ps
// Testbench of sorted_priority_queue: directed and random insert/pop/query
// traffic with random stalls on both channels. Depends on spq_pkg, the two
// channel interfaces and spq_shadow_pkg.

module sorted_priority_queue_tb;

  import spq_pkg::*;
  import spq_shadow_pkg::*;

  localparam int CNT_W        = $clog2(CAPACITY_DEF + 1);
  localparam int RANDOM_ITEMS = 900;
  localparam int QUIET_TAIL   = 100;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  localparam logic signed [PRIO_W-1:0] PRIO_TOP    = PRIO_RESERVED;
  localparam logic signed [PRIO_W-1:0] PRIO_BOTTOM = {1'b1, {(PRIO_W-1){1'b0}}};

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

  logic clk;
  logic rst;
  bit   quiet;      // set in the tail of the run: no idling on either side
  int   cycle_count;

  spq_in_if               cmd_if ();
  spq_out_if #(.CNT_W(CNT_W)) rsp_if ();

  spq_shadow shadow;

  // Recently inserted pairs, reused so that queries hit now and then.
  logic [TAG_W-1:0]         pool_tag  [16];
  logic signed [PRIO_W-1:0] pool_prio [16];
  int                       pool_fill;
  int                       pool_next;

  sorted_priority_queue u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .rsp (rsp_if)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Response side: accept by default, stall in short random bursts.
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      stall_left   = 0;
    end else if (stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      rsp_if.ready <= 1'b0;
      stall_left   = $urandom_range(1, 3) - 1;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // Sample both channels on the edge: check the response first, since it
  // always belongs to an older item than one accepted on the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready) begin
        shadow.check_response(rsp_if.out_tag, rsp_if.out_priority, rsp_if.found,
                              rsp_if.status, rsp_if.now_empty, rsp_if.entry_count);
      end
      if (cmd_if.valid && cmd_if.ready) begin
        shadow.apply_request(action_t'(cmd_if.action), cmd_if.item_tag,
                             cmd_if.item_priority);
      end
    end
  end

  // Stop a hung run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Offer one item, maybe after a short idle burst, and hold it until the
  // edge at which it is taken. Valid stays high into the next item.
  task automatic send_item(input action_t act, input logic [TAG_W-1:0] tag,
                           input logic signed [PRIO_W-1:0] prio);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid         <= 1'b1;
    cmd_if.action        <= act;
    cmd_if.item_tag      <= tag;
    cmd_if.item_priority <= prio;
    do @(posedge clk); while (!(cmd_if.valid && cmd_if.ready));
  endtask

  // Mostly narrow ranges so equal priorities pile up; sometimes the extremes.
  function automatic logic signed [PRIO_W-1:0] pick_priority();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return int'($urandom_range(0, 8)) - 4;
      4, 5:       return $urandom;
      6: begin
        case ($urandom_range(0, 2))
          0:       return PRIO_BOTTOM;
          1:       return PRIO_TOP;
          default: return PRIO_TOP - 1;
        endcase
      end
      default:    return int'($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  function automatic logic [TAG_W-1:0] pick_tag();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom;
  endfunction

  initial begin : stimulus
    traffic_mode_t            mode;
    action_t                  act;
    logic [TAG_W-1:0]         tag;
    logic signed [PRIO_W-1:0] prio;
    int                       sent;
    int                       run_len;
    int                       roll;
    int                       pick;
    bit                       first_round;

    shadow    = new();
    quiet     = 1'b0;
    pool_fill = 0;
    pool_next = 0;

    cmd_if.valid         <= 1'b0;
    cmd_if.action        <= ACT_NOP;
    cmd_if.item_tag      <= '0;
    cmd_if.item_priority <= '0;
    rst                  <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty queue: pop flags empty, query misses, unused code does nothing.
    send_item(ACT_POP,   32'hFFFF_FFFF, PRIO_BOTTOM);
    send_item(ACT_QUERY, 32'h0000_0000, 32'sd0);
    send_item(ACT_NOP,   32'hFFFF_FFFF, PRIO_TOP);
    // Fill with extremes; the reserved priority lands just below the sentinel,
    // and equal priorities keep arrival order.
    send_item(ACT_INSERT, 32'h0000_0000, 32'sd0);
    send_item(ACT_INSERT, 32'hFFFF_FFFF, PRIO_TOP);
    send_item(ACT_INSERT, 32'hA5A5_A5A5, PRIO_TOP - 1);
    send_item(ACT_INSERT, 32'h0000_0001, PRIO_BOTTOM);
    send_item(ACT_INSERT, 32'h0000_0002, 32'sd0);
    send_item(ACT_INSERT, 32'h0000_0003, -32'sd1);
    // Queries: reserved priority folds onto the one below it, both ways.
    send_item(ACT_QUERY, 32'hFFFF_FFFF, PRIO_TOP - 1);
    send_item(ACT_QUERY, 32'hA5A5_A5A5, PRIO_TOP);
    send_item(ACT_QUERY, 32'h0000_0001, PRIO_BOTTOM);
    send_item(ACT_QUERY, 32'h0000_0001, 32'sd0);
    send_item(ACT_NOP,   32'h5A5A_5A5A, 32'sh5555_5555);
    // Drain in order, then one pop past empty.
    repeat (7) send_item(ACT_POP, $urandom, $urandom);

    // Random traffic in runs: filling runs reach full, draining runs reach
    // empty, mixed runs stir the middle. Open with a fill to hit full early.
    sent        = 0;
    first_round = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      mode        = first_round ? MODE_FILL : traffic_mode_t'($urandom_range(0, 2));
      run_len     = (mode == MODE_MIXED) ? $urandom_range(20, 60) : $urandom_range(70, 100);
      first_round = 1'b0;
      for (int k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        case (mode)
          MODE_FILL:  act = (roll < 85) ? ACT_INSERT : (roll < 93) ? ACT_QUERY :
                            (roll < 99) ? ACT_POP : ACT_NOP;
          MODE_DRAIN: act = (roll < 10) ? ACT_INSERT : (roll < 20) ? ACT_QUERY :
                            (roll < 98) ? ACT_POP : ACT_NOP;
          default:    act = (roll < 40) ? ACT_INSERT : (roll < 75) ? ACT_POP :
                            (roll < 97) ? ACT_QUERY : ACT_NOP;
        endcase
        tag  = pick_tag();
        prio = pick_priority();
        // Aim most queries at something inserted lately.
        if (act == ACT_QUERY && pool_fill > 0 && $urandom_range(0, 3) != 0) begin
          pick = $urandom_range(0, pool_fill - 1);
          prio = pool_prio[pick];
          if ($urandom_range(0, 4) != 0) tag = pool_tag[pick];
        end
        if (act == ACT_INSERT) begin
          pool_tag[pool_next]  = tag;
          pool_prio[pool_next] = prio;
          pool_next            = (pool_next + 1) % 16;
          if (pool_fill < 16) pool_fill++;
        end
        send_item(act, tag, prio);
        sent++;
        quiet = (sent >= RANDOM_ITEMS - QUIET_TAIL);
      end
    end
    cmd_if.valid <= 1'b0;

    // Let the last item reach the shadow, wait out the responses, then keep
    // watching for anything unexpected.
    @(posedge clk);
    while (shadow.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.pending() != 0) shadow.report_mismatch("responses still awaited at end");

    if (shadow.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/spq_pkg.sv
rtl/spq_in_if.sv
rtl/spq_out_if.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
tb/sv/spq_shadow_pkg.sv
tb/sv/sorted_priority_queue_tb.sv
